// ----- src/sparse_row_store_accumulator_unit_assert.svh -----
// Assertion macros for the checker file.
`ifndef SPARSE_ROW_STORE_ACCUMULATOR_UNIT_ASSERT_SVH
`define SPARSE_ROW_STORE_ACCUMULATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SRSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define SRSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/srsa_pkg.sv -----
// Package: command and status codes, field widths and saturating add.
package srsa_pkg;

    localparam int CMD_W   = 3;
    localparam int ROW_W   = 8;
    localparam int COLIN_W = 16;
    localparam int VAL_W   = 32;
    localparam int SLOT_W  = 4;
    localparam int STAT_W  = 2;
    localparam int RCNT_W  = 5;
    localparam int CFGD_W  = 17;
    localparam int NROW_W  = 9;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_cmd CMD_SET   = 3'd0;
    localparam t_cmd CMD_ADD   = 3'd1;
    localparam t_cmd CMD_QUERY = 3'd2;
    localparam t_cmd CMD_CMPR  = 3'd3;
    localparam t_cmd CMD_RDSLOT = 3'd4;
    localparam t_cmd CMD_DIAG  = 3'd5;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_BOUNDS = 2'd1;
    localparam t_status ST_FULL   = 2'd2;
    localparam t_status ST_UNINIT = 2'd3;

    localparam logic [1:0] CFG_ROW_LIMIT = 2'd0;
    localparam logic [1:0] CFG_COL_LIMIT = 2'd1;

    function automatic logic [VAL_W-1:0] sat_add(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
        logic [VAL_W-1:0] s;
        s = a + b;
        if (!(a[VAL_W-1] ^ b[VAL_W-1]) && (a[VAL_W-1] ^ s[VAL_W-1])) begin
            s = a[VAL_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
        return s;
    endfunction

endpackage

// ----- src/srsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module srsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- src/sparse_row_store_accumulator_unit.sv -----
// Top level: sparse row store accumulator, one memory sequencer over two RAMs.
//
// Usage:
//  - Commands arrive on the s_axis channel (tuser = cmd, tdata = row, col, value,
//    slot). One result per command leaves on m_axis (tuser = status, tdata =
//    out_value, out_col, row_count).
//  - The row limit (index 0) and the column limit (index 1) are written through
//    the cfg channel, which is always ready; write them only while idle.
//  - One command is in flight at a time. Set, add, set diagonal and query
//    read the row count, then scan the row's slots one per cycle through
//    the slot RAM read port, visiting at most ROW_SLOTS slots. Read slot
//    reads the addressed slot directly.
//  - Compress bubble-sorts every row in use in place with a carried element.
//  - After reset the row-count RAM is cleared, one row a cycle, and
//    s_axis_tready stays low until every row is cleared.
//  - The result sits in an output register; the next command is accepted
//    while it waits. A new result waits in the block until m_axis is free.
module sparse_row_store_accumulator_unit #(
    parameter int MAX_ROWS  = 256,
    parameter int ROW_SLOTS = 16,
    parameter int COL_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // row[7:0], col[23:8], value[55:24], slot[59:56]
    input  srsa_pkg::t_cmd s_axis_tuser,  // cmd[2:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // out_value[31:0], out_col[47:32], row_count[52:48]
    output srsa_pkg::t_status m_axis_tuser,  // status[1:0]
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);
    import srsa_pkg::*;

    localparam int RB    = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
    localparam int KB    = ROW_SLOTS > 1 ? $clog2(ROW_SLOTS) : 1;
    localparam int SB    = $clog2(ROW_SLOTS + 1);
    localparam int DEPTH = MAX_ROWS * ROW_SLOTS;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int DW    = COL_BITS + VAL_W;
    localparam logic [SB-1:0] FULL_CNT = SB'(ROW_SLOTS);
    localparam logic [17:0]   MAXR18   = 18'(MAX_ROWS);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_CNT     = 4'd2;
    localparam logic [3:0] S_SCAN    = 4'd3;
    localparam logic [3:0] S_RDS     = 4'd4;
    localparam logic [3:0] S_CMP_CNT = 4'd5;
    localparam logic [3:0] S_CMP_LD  = 4'd6;
    localparam logic [3:0] S_CMP_RUN = 4'd7;
    localparam logic [3:0] S_CMP_END = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    function automatic logic [AW-1:0] f_addr(logic [RB-1:0] r, logic [KB-1:0] k);
        return AW'(AW'(r) * AW'(ROW_SLOTS) + AW'(k));
    endfunction

    // registers
    logic [3:0]          r_state, n_state;
    logic [RB-1:0]       r_clr, n_clr;
    logic [NROW_W-1:0]   r_row_limit;
    logic [CFGD_W-1:0]   r_col_limit;
    t_cmd                r_cmd, n_cmd;
    logic [RB-1:0]       r_row, n_row;
    logic [COL_BITS-1:0] r_key, n_key;
    logic [COLIN_W-1:0]  r_col, n_col;
    logic [VAL_W-1:0]    r_val, n_val;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic                r_row_ok, n_row_ok;
    logic                r_rows0, n_rows0;
    logic [SB-1:0]       r_cnt, n_cnt;
    logic [KB-1:0]       r_k, n_k;
    logic [RB-1:0]       r_crow, n_crow;
    logic [SB-1:0]       r_n, n_n;
    logic [SB-1:0]       r_pass, n_pass;
    logic [DW-1:0]       r_carry, n_carry;
    t_status             r_res_st, n_res_st;
    logic [VAL_W-1:0]    r_res_val, n_res_val;
    logic [COLIN_W-1:0]  r_res_col, n_res_col;
    logic [RCNT_W-1:0]   r_res_cnt, n_res_cnt;
    logic                r_ovalid, n_ovalid;
    t_status             r_o_st, n_o_st;
    logic [VAL_W-1:0]    r_o_val, n_o_val;
    logic [COLIN_W-1:0]  r_o_col, n_o_col;
    logic [RCNT_W-1:0]   r_o_cnt, n_o_cnt;

    // memory ports
    logic          cnt_we;
    logic [RB-1:0] cnt_waddr, cnt_raddr;
    logic [SB-1:0] cnt_wdata, cnt_rdata;
    logic          dat_we;
    logic [AW-1:0] dat_waddr, dat_raddr;
    logic [DW-1:0] dat_wdata, dat_rdata;

    srsa_ram #(.WIDTH(SB), .DEPTH(MAX_ROWS)) u_cnt_ram (
        .i_clk  (i_clk),
        .i_we   (cnt_we),
        .i_waddr(cnt_waddr),
        .i_wdata(cnt_wdata),
        .i_raddr(cnt_raddr),
        .o_rdata(cnt_rdata)
    );

    srsa_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_dat_ram (
        .i_clk  (i_clk),
        .i_we   (dat_we),
        .i_waddr(dat_waddr),
        .i_wdata(dat_wdata),
        .i_raddr(dat_raddr),
        .o_rdata(dat_rdata)
    );

    // input field unpacking
    logic [ROW_W-1:0]    in_row;
    logic [COLIN_W-1:0]  in_col;
    logic [RB+ROW_W-1:0] in_row_x;
    logic [COL_BITS+COLIN_W-1:0] key_col_x, key_row_x, out_col_x;
    logic [KB+SLOT_W-1:0] slot_x;
    logic [17:0]         rows18;
    logic [COL_BITS-1:0] rd_col;
    logic [VAL_W-1:0]    rd_val;
    logic                last, match;

    assign in_row    = s_axis_tdata[7:0];
    assign in_col    = s_axis_tdata[23:8];
    assign in_row_x  = (RB+ROW_W)'(in_row);
    assign key_col_x = (COL_BITS+COLIN_W)'(in_col);
    assign key_row_x = (COL_BITS+COLIN_W)'(in_row);
    assign slot_x    = (KB+SLOT_W)'(r_slot);
    assign rows18    = (18'(r_row_limit) < MAXR18) ? 18'(r_row_limit) : MAXR18;
    assign rd_col    = dat_rdata[DW-1:VAL_W];
    assign rd_val    = dat_rdata[VAL_W-1:0];
    assign out_col_x = (COL_BITS+COLIN_W)'(rd_col);
    assign match     = (rd_col == r_key);
    assign last      = (SB'(r_k) + SB'(1)) == r_cnt;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_o_st;
    assign m_axis_tdata  = {3'b000, r_o_cnt, r_o_col, r_o_val};

    always_comb begin
        n_state = r_state;  n_clr = r_clr;    n_cmd = r_cmd;    n_row = r_row;
        n_key = r_key;      n_col = r_col;    n_val = r_val;    n_slot = r_slot;
        n_row_ok = r_row_ok; n_rows0 = r_rows0; n_cnt = r_cnt;  n_k = r_k;
        n_crow = r_crow;    n_n = r_n;        n_pass = r_pass;  n_carry = r_carry;
        n_res_st = r_res_st; n_res_val = r_res_val; n_res_col = r_res_col;
        n_res_cnt = r_res_cnt;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_o_st = r_o_st;    n_o_val = r_o_val; n_o_col = r_o_col; n_o_cnt = r_o_cnt;
        cnt_we = 1'b0;  cnt_waddr = r_row; cnt_wdata = r_cnt; cnt_raddr = r_row;
        dat_we = 1'b0;  dat_waddr = f_addr(r_row, r_k); dat_wdata = r_carry;
        dat_raddr = f_addr(r_row, r_k);

        unique case (r_state)
            S_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_clr;
                cnt_wdata = '0;
                if (r_clr == RB'(MAX_ROWS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + RB'(1);
                end
            end
            S_IDLE: begin
                cnt_raddr = in_row_x[RB-1:0];
                if (s_axis_tvalid) begin
                    n_cmd    = s_axis_tuser;
                    n_row    = in_row_x[RB-1:0];
                    n_col    = in_col;
                    n_val    = s_axis_tdata[55:24];
                    n_slot   = s_axis_tdata[59:56];
                    n_key    = (s_axis_tuser == CMD_DIAG) ? key_row_x[COL_BITS-1:0]
                                                          : key_col_x[COL_BITS-1:0];
                    n_row_ok = 18'(in_row) < rows18;
                    n_rows0  = (rows18 == 18'd0);
                    n_state  = S_CNT;
                end
            end
            S_CNT: begin
                n_cnt     = cnt_rdata;
                n_res_st  = ST_OK;
                n_res_val = '0;
                n_res_col = '0;
                n_res_cnt = r_row_ok ? RCNT_W'(cnt_rdata) : '0;
                n_k       = '0;
                dat_raddr = f_addr(r_row, '0);
                n_state   = S_OUT;
                unique case (r_cmd) inside
                    CMD_SET, CMD_ADD, CMD_DIAG, CMD_QUERY: begin
                        if (r_rows0 && r_cmd != CMD_QUERY) begin
                            n_res_st = ST_UNINIT;
                        end else if (!r_row_ok || ((r_cmd == CMD_SET || r_cmd == CMD_ADD)
                                     && 17'(r_col) >= r_col_limit)) begin
                            n_res_st = ST_BOUNDS;
                        end else if (cnt_rdata != '0) begin
                            n_state = S_SCAN;
                        end else if (r_cmd != CMD_QUERY) begin
                            // empty row: append at slot zero
                            if (cnt_rdata == FULL_CNT) begin
                                n_res_st = ST_FULL;
                            end else begin
                                dat_we    = 1'b1;
                                dat_waddr = f_addr(r_row, '0);
                                dat_wdata = {r_key, r_val};
                                cnt_we    = 1'b1;
                                cnt_wdata = cnt_rdata + SB'(1);
                                n_res_cnt = RCNT_W'(cnt_rdata + SB'(1));
                            end
                        end
                    end
                    CMD_RDSLOT: begin
                        if (r_rows0) begin
                            n_res_st = ST_UNINIT;
                        end else if (!r_row_ok || 9'(r_slot) >= 9'(cnt_rdata)
                                     || 9'(r_slot) >= 9'(ROW_SLOTS)) begin
                            n_res_st = ST_BOUNDS;
                        end else begin
                            dat_raddr = f_addr(r_row, slot_x[KB-1:0]);
                            n_state   = S_RDS;
                        end
                    end
                    CMD_CMPR: begin
                        if (!r_rows0) begin
                            n_crow    = '0;
                            cnt_raddr = '0;
                            n_state   = S_CMP_CNT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                dat_raddr = f_addr(r_row, r_k + KB'(1));
                if (match) begin
                    n_state = S_OUT;
                    if (r_cmd == CMD_QUERY) begin
                        n_res_val = rd_val;
                    end else begin
                        dat_we    = 1'b1;
                        dat_waddr = f_addr(r_row, r_k);
                        dat_wdata = {r_key, (r_cmd == CMD_ADD) ? sat_add(rd_val, r_val)
                                                               : r_val};
                    end
                end else if (last) begin
                    n_state = S_OUT;
                    if (r_cmd != CMD_QUERY) begin
                        if (r_cnt == FULL_CNT) begin
                            n_res_st = ST_FULL;
                        end else begin
                            dat_we    = 1'b1;
                            dat_waddr = f_addr(r_row, KB'(r_cnt));
                            dat_wdata = {r_key, r_val};
                            cnt_we    = 1'b1;
                            cnt_wdata = r_cnt + SB'(1);
                            n_res_cnt = RCNT_W'(r_cnt + SB'(1));
                        end
                    end
                end else begin
                    n_k = r_k + KB'(1);
                end
            end
            S_RDS: begin
                n_res_val = rd_val;
                n_res_col = out_col_x[COLIN_W-1:0];
                n_state   = S_OUT;
            end
            S_CMP_CNT: begin
                n_n       = cnt_rdata;
                n_pass    = '0;
                n_row     = r_crow;
                dat_raddr = f_addr(r_crow, '0);
                if (cnt_rdata > SB'(1)) begin
                    n_state = S_CMP_LD;
                end else if (18'(r_crow) + 18'd1 == rows18) begin
                    n_state = S_OUT;
                end else begin
                    n_crow    = r_crow + RB'(1);
                    cnt_raddr = r_crow + RB'(1);
                end
            end
            S_CMP_LD: begin
                n_carry   = dat_rdata;
                n_k       = KB'(1);
                dat_raddr = f_addr(r_row, KB'(1));
                n_state   = S_CMP_RUN;
            end
            S_CMP_RUN: begin
                // carry holds the largest so far; strict compare keeps ties stable
                dat_we    = 1'b1;
                dat_waddr = f_addr(r_row, r_k - KB'(1));
                if (r_carry[DW-1:VAL_W] > rd_col) begin
                    dat_wdata = dat_rdata;
                end else begin
                    dat_wdata = r_carry;
                    n_carry   = dat_rdata;
                end
                if (SB'(r_k) == r_n - SB'(1)) begin
                    n_state = S_CMP_END;
                end else begin
                    n_k       = r_k + KB'(1);
                    dat_raddr = f_addr(r_row, r_k + KB'(1));
                end
            end
            S_CMP_END: begin
                dat_we    = 1'b1;
                dat_waddr = f_addr(r_row, r_k);
                dat_wdata = r_carry;
                dat_raddr = f_addr(r_row, '0);
                cnt_raddr = r_crow + RB'(1);
                if (r_pass + SB'(2) == r_n) begin
                    if (18'(r_crow) + 18'd1 == rows18) begin
                        n_state = S_OUT;
                    end else begin
                        n_crow  = r_crow + RB'(1);
                        n_state = S_CMP_CNT;
                    end
                end else begin
                    n_pass  = r_pass + SB'(1);
                    n_state = S_CMP_LD;
                end
            end
            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_o_st   = r_res_st;
                    n_o_val  = r_res_val;
                    n_o_col  = r_res_col;
                    n_o_cnt  = r_res_cnt;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_ovalid    <= 1'b0;
            r_row_limit <= '0;
            r_col_limit <= '0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_ROW_LIMIT) begin
                    r_row_limit <= i_cfg_data[NROW_W-1:0];
                end else if (i_cfg_index == CFG_COL_LIMIT) begin
                    r_col_limit <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;   r_row <= n_row;   r_key <= n_key;   r_col <= n_col;
        r_val <= n_val;   r_slot <= n_slot; r_row_ok <= n_row_ok; r_rows0 <= n_rows0;
        r_cnt <= n_cnt;   r_k <= n_k;       r_crow <= n_crow; r_n <= n_n;
        r_pass <= n_pass; r_carry <= n_carry;
        r_res_st <= n_res_st;  r_res_val <= n_res_val;
        r_res_col <= n_res_col; r_res_cnt <= n_res_cnt;
        r_o_st <= n_o_st;  r_o_val <= n_o_val;  r_o_col <= n_o_col;  r_o_cnt <= n_o_cnt;
    end
endmodule

// ----- src/srsa_checker.sv -----
// Port checker for the sparse row store accumulator, bound to the top level.
`include "sparse_row_store_accumulator_unit_assert.svh"

module srsa_checker #(
    parameter int ROW_SLOTS = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import srsa_pkg::*;

    `SRSA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `SRSA_ASSERT_NOW(a_err_no_data, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser != ST_OK, m_axis_tdata[47:0] == 48'd0)
    `SRSA_ASSERT_NOW(a_uninit_empty, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == ST_UNINIT, m_axis_tdata[52:48] == 5'd0)
    `SRSA_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, m_axis_tvalid, 32'(m_axis_tdata[52:48]) <= 32'(ROW_SLOTS))
endmodule

bind sparse_row_store_accumulator_unit srsa_checker #(.ROW_SLOTS(ROW_SLOTS)) u_srsa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for the sparse row store accumulator unit.
`timescale 1ns / 1ps

import srsa_pkg::*;

class row_store_scoreboard;
    logic [8:0]  row_limit;
    logic [16:0] col_limit;
    logic [4:0]  cnt [256];
    logic [15:0] col_at [256][16];
    logic [31:0] val_at [256][16];
    // expected results, oldest first: {status, row_count, out_col, out_value}
    logic [54:0] pending [$];
    int errors;

    function new();
        row_limit = 0;
        col_limit = 0;
        errors = 0;
        foreach (cnt[r]) cnt[r] = 0;
    endfunction

    function int find_slot(int r, logic [15:0] c);
        for (int k = 0; k < cnt[r]; k++) if (col_at[r][k] == c) return k;
        return 16;
    endfunction

    function t_status place(int r, logic [15:0] c, logic [31:0] v, bit accum);
        int k;
        logic [31:0] s;
        k = find_slot(r, c);
        if (k < 16) begin
            if (accum) begin
                s = val_at[r][k] + v;
                // overflow when both operands agree in sign and the sum does not
                if (val_at[r][k][31] == v[31] && s[31] != v[31])
                    s = v[31] ? 32'h8000_0000 : 32'h7fff_ffff;
                val_at[r][k] = s;
            end else begin
                val_at[r][k] = v;
            end
            return ST_OK;
        end
        if (cnt[r] >= 16) return ST_FULL;
        col_at[r][cnt[r]] = c;
        val_at[r][cnt[r]] = v;
        cnt[r]++;
        return ST_OK;
    endfunction

    // insertion sort keeps equal columns in storage order
    function void sort_row(int r);
        int j;
        logic [15:0] c;
        logic [31:0] v;
        for (int i = 1; i < cnt[r]; i++) begin
            c = col_at[r][i];
            v = val_at[r][i];
            j = i;
            while (j > 0 && col_at[r][j-1] > c) begin
                col_at[r][j] = col_at[r][j-1];
                val_at[r][j] = val_at[r][j-1];
                j--;
            end
            col_at[r][j] = c;
            val_at[r][j] = v;
        end
    endfunction

    function void note_command(t_cmd cmd, logic [7:0] row, logic [15:0] col,
                               logic [31:0] v, logic [3:0] slot);
        int rows;
        bit row_ok;
        t_status st;
        logic [31:0] ov;
        logic [15:0] oc;
        logic [54:0] entry;
        int k;
        rows = (row_limit > 256) ? 256 : row_limit;
        row_ok = row < rows;
        st = ST_OK; ov = 0; oc = 0;
        case (cmd)
            CMD_SET, CMD_ADD: begin
                if (rows == 0) st = ST_UNINIT;
                else if (!row_ok || col >= col_limit) st = ST_BOUNDS;
                else st = place(row, col, v, cmd == CMD_ADD);
            end
            CMD_DIAG: begin
                if (rows == 0) st = ST_UNINIT;
                else if (!row_ok) st = ST_BOUNDS;
                else st = place(row, {8'd0, row}, v, 0);
            end
            CMD_QUERY: begin
                if (!row_ok) st = ST_BOUNDS;
                else begin
                    k = find_slot(row, col);
                    if (k < 16) ov = val_at[row][k];
                end
            end
            CMD_CMPR: for (int r = 0; r < rows; r++) sort_row(r);
            CMD_RDSLOT: begin
                if (rows == 0) st = ST_UNINIT;
                else if (!row_ok || slot >= cnt[row]) st = ST_BOUNDS;
                else begin
                    ov = val_at[row][slot];
                    oc = col_at[row][slot];
                end
            end
            default: ;
        endcase
        entry = {st, row_ok ? cnt[row] : 5'd0, oc, ov};
        pending.insert(pending.size(), entry);
    endfunction

    function void check_result(t_status st, logic [55:0] data);
        logic [54:0] got, want;
        got = {st, data[52:48], data[47:32], data[31:0]};
        if (pending.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got[54:53] != want[54:53])
            $display("%0t: status expected %0d actual %0d", $time, want[54:53], got[54:53]);
        if (got[52:48] != want[52:48])
            $display("%0t: row_count expected %0d actual %0d", $time, want[52:48], got[52:48]);
        if (got[47:32] != want[47:32])
            $display("%0t: out_col expected %h actual %h", $time, want[47:32], got[47:32]);
        if (got[31:0] != want[31:0])
            $display("%0t: out_value expected %h actual %h", $time, want[31:0], got[31:0]);
        if (got != want) errors++;
    endfunction
endclass

module testbench;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = 0;
    t_cmd        s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [55:0] m_axis_tdata;
    t_status     m_axis_tuser;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 0;
    logic [16:0] i_cfg_data = 0;

    row_store_scoreboard board = new();
    int send_idle_pct = 37;   // sender gap chance, percent
    int recv_idle_pct = 52;   // receiver stall chance, percent
    int quiet_cycles = 0;

    sparse_row_store_accumulator_unit dut (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    // receiver: random stalls, each result checked as its transaction completes
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tuser, m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: the quiet limit leaves room for a compress over 256 full rows
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 400000) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [16:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        if (idx == CFG_ROW_LIMIT) board.row_limit = data[8:0];
        else board.col_limit = data;
        @(posedge i_clk);
    endtask

    // tvalid stays high between back-to-back transactions and drops while idling
    task automatic send_cmd(t_cmd cmd, logic [7:0] row, logic [15:0] col,
                            logic [31:0] v, logic [3:0] slot);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'd0, slot, v, col, row};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_command(cmd, row, col, v, slot);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // mostly well-formed traffic up to the row and column hints; small hints make rows fill and hit
    task automatic random_phase(int n, int rows_hint, int cols_hint);
        t_cmd c;
        int p;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(99);
            if (p < 30) c = CMD_SET;
            else if (p < 55) c = CMD_ADD;
            else if (p < 72) c = CMD_QUERY;
            else if (p < 87) c = CMD_RDSLOT;
            else if (p < 93) c = CMD_DIAG;
            else if (p < 96) c = CMD_CMPR;
            else c = t_cmd'($urandom_range(7));
            if ($urandom_range(9) == 0)
                send_cmd(c, 8'($urandom), 16'($urandom), $urandom, 4'($urandom));
            else
                send_cmd(c, 8'($urandom_range(rows_hint)), 16'($urandom_range(cols_hint)),
                         ($urandom_range(3) == 0) ?
                             {1'($urandom_range(1)), 31'h7fff_fff0} : $urandom,
                         4'($urandom_range(16)));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        // uninitialised matrix
        send_cmd(CMD_SET, 0, 0, 32'h1, 0);
        send_cmd(CMD_ADD, 0, 0, 32'h1, 0);
        send_cmd(CMD_QUERY, 0, 0, 0, 0);
        send_cmd(CMD_CMPR, 0, 0, 0, 0);
        send_cmd(CMD_RDSLOT, 0, 0, 0, 0);
        send_cmd(CMD_DIAG, 0, 0, 32'h5, 0);
        drain();

        write_reg(CFG_ROW_LIMIT, 2);
        write_reg(CFG_COL_LIMIT, 17'h10000);
        // fill row 1 to capacity, reversed columns, then overflow it
        for (int k = 0; k < 16; k++)
            send_cmd(CMD_SET, 1, 16'(16'hffff - k), 32'({$urandom, 1'b0}), 0);
        send_cmd(CMD_SET, 1, 16'h1234, 32'h1, 0);
        send_cmd(CMD_ADD, 1, 16'hffff, 32'h7fff_ffff, 0);
        send_cmd(CMD_ADD, 1, 16'hffff, 32'h7fff_ffff, 0);
        send_cmd(CMD_ADD, 1, 16'hfffe, 32'h8000_0000, 0);
        send_cmd(CMD_ADD, 1, 16'hfffe, 32'h8000_0000, 0);
        send_cmd(CMD_DIAG, 2, 0, 32'h1, 0);
        send_cmd(CMD_DIAG, 1, 0, 32'h1, 0);
        send_cmd(CMD_CMPR, 0, 0, 0, 0);
        send_cmd(CMD_RDSLOT, 1, 0, 0, 15);
        send_cmd(CMD_RDSLOT, 0, 0, 0, 0);
        send_cmd(3'd7, 0, 0, 0, 0);
        drain();

        // all bounds; also exercises a row limit beyond MAX_ROWS
        write_reg(CFG_ROW_LIMIT, 9'h1ff);
        write_reg(CFG_COL_LIMIT, 17'h1ffff);
        random_phase(300, 255, 65535);
        drain();

        write_reg(CFG_ROW_LIMIT, 6);
        write_reg(CFG_COL_LIMIT, 24);
        random_phase(350, 7, 25);
        drain();

        send_idle_pct = 52;
        recv_idle_pct = 37;
        write_reg(CFG_ROW_LIMIT, 1);
        write_reg(CFG_COL_LIMIT, 1);
        random_phase(150, 1, 2);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_ROW_LIMIT, 256);
        write_reg(CFG_COL_LIMIT, 40);
        random_phase(430, 255, 40);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
